@@ src/c2sp_pkg.sv @@
// Shared constants, types and the arctangent table of the Cartesian to spherical converter.
package c2sp_pkg;

    localparam int COORD_BITS = 24;
    localparam int ITERATIONS = 24;
    localparam int GUARD_BITS = 6;

    localparam int DP_W    = COORD_BITS + GUARD_BITS + 4;
    localparam int MAG_W   = DP_W - 1;
    localparam int ANG_W   = 34;
    localparam int GAIN_HW = 16;
    localparam int PROD_W  = MAG_W + GAIN_HW;

    localparam logic [GAIN_HW-1:0] GAIN_HI = 16'h9B74;
    localparam logic [GAIN_HW-1:0] GAIN_LO = 16'hEDA8;

    localparam logic signed [ANG_W-1:0] ANG_PI     = 34'sd2147483648;
    localparam int                      ANG_SHIFT  = 32 - COORD_BITS;
    localparam logic signed [ANG_W-1:0] ANG_HALF   = ANG_W'((64'sd1 <<< ANG_SHIFT) >>> 1);
    localparam logic signed [ANG_W-1:0] ANG_OUT_PI = ANG_W'(64'sd1 <<< (COORD_BITS - 1));

    localparam int VEC_LAT = ITERATIONS + 3;

    localparam int IN_TDATA_W   = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 * COORD_BITS + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_vec_status;

    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051D;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2E;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517C;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A2F;
            19:      v = 32'h00000517;
            20:      v = 32'h0000028B;
            21:      v = 32'h00000145;
            22:      v = 32'h000000A2;
            23:      v = 32'h00000051;
            24:      v = 32'h00000028;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000002;
            29:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ src/c2sp_vectoring.sv @@
// Pipelined vectoring CORDIC: pre-rotation, one stage per iteration, and gain compensation.
module c2sp_vectoring (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [c2sp_pkg::DP_W-1:0]    i_x,
    input  logic signed [c2sp_pkg::DP_W-1:0]    i_y,
    output c2sp_pkg::t_vec_status               o_status,
    output logic        [c2sp_pkg::MAG_W-1:0]   o_mag,
    output logic signed [c2sp_pkg::ANG_W-1:0]   o_ang
);
    import c2sp_pkg::*;

    logic signed [DP_W-1:0]  r_x    [0:ITERATIONS];
    logic signed [DP_W-1:0]  r_y    [0:ITERATIONS];
    logic signed [ANG_W-1:0] r_a    [0:ITERATIONS];
    logic                    r_v    [0:ITERATIONS];
    logic                    r_zero [0:ITERATIONS];

    logic signed [DP_W-1:0]  n_x0;
    logic signed [DP_W-1:0]  n_y0;
    logic signed [ANG_W-1:0] n_a0;

    logic [PROD_W-1:0]       r_p_hi;
    logic [PROD_W-1:0]       r_p_lo;
    logic signed [ANG_W-1:0] r_ga;
    logic                    r_gv;
    logic                    r_gz;
    logic [PROD_W:0]         n_sum;
    logic [MAG_W-1:0]        r_mag;
    logic signed [ANG_W-1:0] r_ang;
    logic                    r_ov;
    logic                    r_oz;

    always_comb begin
        if (i_x < 0) begin
            n_x0 = -i_x;
            n_y0 = -i_y;
            n_a0 = (i_y >= 0) ? ANG_PI : -ANG_PI;
        end else begin
            n_x0 = i_x;
            n_y0 = i_y;
            n_a0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_a[0]    <= n_a0;
            r_zero[0] <= (i_x == 0) && (i_y == 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
        logic signed [DP_W-1:0]  sx;
        logic signed [DP_W-1:0]  sy;
        logic signed [ANG_W-1:0] t;
        logic signed [DP_W-1:0]  n_x;
        logic signed [DP_W-1:0]  n_y;
        logic signed [ANG_W-1:0] n_a;

        always_comb begin
            sx = r_x[k] >>> k;
            sy = r_y[k] >>> k;
            t  = signed'(ANG_W'(atan_entry(k)));
            if (r_y[k] >= 0) begin
                n_x = r_x[k] + sy;
                n_y = r_y[k] - sx;
                n_a = r_a[k] + t;
            end else begin
                n_x = r_x[k] - sy;
                n_y = r_y[k] + sx;
                n_a = r_a[k] - t;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= n_x;
                r_y[k+1]    <= n_y;
                r_a[k+1]    <= n_a;
                r_zero[k+1] <= r_zero[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_hi <= r_x[ITERATIONS][MAG_W-1:0] * GAIN_HI;
            r_p_lo <= r_x[ITERATIONS][MAG_W-1:0] * GAIN_LO;
            r_ga   <= r_a[ITERATIONS];
            r_gz   <= r_zero[ITERATIONS];
        end
    end

    assign n_sum = {1'b0, r_p_hi} + (PROD_W + 1)'(r_p_lo >> GAIN_HW);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_sum[GAIN_HW +: MAG_W];
            r_ang <= r_ga;
            r_oz  <= r_gz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_gv <= r_v[ITERATIONS];
            r_ov <= r_gv;
        end
    end

    assign o_status.valid = r_ov;
    assign o_status.zero  = r_oz;
    assign o_mag          = r_mag;
    assign o_ang          = r_ang;

endmodule

@@ src/c2sp_format.sv @@
// Output stage: rounds and clamps both angles, scales and saturates both radii.
module c2sp_format (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  c2sp_pkg::t_vec_status                  i_status,
    input  logic                                   i_zero1,
    input  logic        [c2sp_pkg::MAG_W-1:0]      i_mag1,
    input  logic signed [c2sp_pkg::ANG_W-1:0]      i_ang1,
    input  logic        [c2sp_pkg::MAG_W-1:0]      i_mag2,
    input  logic signed [c2sp_pkg::ANG_W-1:0]      i_ang2,
    output logic                                   o_valid,
    output logic        [c2sp_pkg::COORD_BITS-1:0] o_planar_radius,
    output logic signed [c2sp_pkg::COORD_BITS:0]   o_azimuth,
    output logic        [c2sp_pkg::COORD_BITS-1:0] o_full_radius,
    output logic        [c2sp_pkg::COORD_BITS-1:0] o_polar_angle
);
    import c2sp_pkg::*;

    function automatic logic [COORD_BITS-1:0] radius_sat(input logic [MAG_W-1:0] m);
        logic [COORD_BITS-1:0] v;
        if (|m[MAG_W-1:GUARD_BITS+COORD_BITS]) begin
            v = '1;
        end else begin
            v = m[GUARD_BITS +: COORD_BITS];
        end
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] angle_round(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] s;
        s = a + ANG_HALF;
        return s >>> ANG_SHIFT;
    endfunction

    logic signed [ANG_W-1:0]      az_r;
    logic signed [ANG_W-1:0]      pol_r;
    logic signed [ANG_W-1:0]      n_az;
    logic signed [ANG_W-1:0]      n_pol;
    logic                         r_valid;
    logic [COORD_BITS-1:0]        r_planar;
    logic signed [COORD_BITS:0]   r_az;
    logic [COORD_BITS-1:0]        r_full;
    logic [COORD_BITS-1:0]        r_pol;

    always_comb begin
        az_r  = angle_round(i_ang1);
        pol_r = angle_round(i_ang2);
        if (i_zero1) begin
            n_az = '0;
        end else if (az_r > ANG_OUT_PI) begin
            n_az = ANG_OUT_PI;
        end else if (az_r < -ANG_OUT_PI) begin
            n_az = -ANG_OUT_PI;
        end else begin
            n_az = az_r;
        end
        if (i_status.zero) begin
            n_pol = '0;
        end else if (pol_r > ANG_OUT_PI) begin
            n_pol = ANG_OUT_PI;
        end else if (pol_r < 0) begin
            n_pol = '0;
        end else begin
            n_pol = pol_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_planar <= radius_sat(i_mag1);
            r_az     <= n_az[COORD_BITS:0];
            r_full   <= radius_sat(i_mag2);
            r_pol    <= n_pol[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_status.valid;
        end
    end

    assign o_valid         = r_valid;
    assign o_planar_radius = r_planar;
    assign o_azimuth       = r_az;
    assign o_full_radius   = r_full;
    assign o_polar_angle   = r_pol;

endmodule

@@ src/cartesian_to_spherical_polar.sv @@
// Top level of the Cartesian to polar and spherical coordinate converter.
// Usage:
// Each item on the slave stream is one point (x, y, z) of signed coordinates.
// Each item on the master stream carries the planar radius sqrt(x^2+y^2), the
// azimuth atan2(y, x), the full radius sqrt(x^2+y^2+z^2) and the polar angle
// measured from the +z axis. Angles use 2^(COORD_BITS-1) for pi radians.
// Two vectoring CORDICs of ITERATIONS stages each are chained: the first one
// works on (x, y), the second one on (z, planar radius).
// Each CORDIC has a pre-rotation register, one register per iteration and two
// gain stages; the output register follows the second CORDIC.
// Throughput is one item per cycle; a new item is accepted every cycle while
// the output register is empty or being read.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_s_tready drops in the same cycle; nothing is lost or repeated.
// Synchronous reset clears all valid bits; no item is in flight afterwards.
module cartesian_to_spherical_polar (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // x_coord, y_coord, z_coord from the lowest bit up.
    input  logic [c2sp_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // planar_radius, azimuth, full_radius, polar_angle from the lowest bit up, zero padded.
    output logic [c2sp_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);
    import c2sp_pkg::*;

    logic                      en;
    logic signed [DP_W-1:0]    x_in;
    logic signed [DP_W-1:0]    y_in;
    logic signed [DP_W-1:0]    z_in;
    t_vec_status               st1;
    t_vec_status               st2;
    logic [MAG_W-1:0]          mag1;
    logic signed [ANG_W-1:0]   ang1;
    logic [MAG_W-1:0]          mag2;
    logic signed [ANG_W-1:0]   ang2;
    logic signed [DP_W-1:0]    y2_in;

    logic signed [DP_W-1:0]    r_z_dly    [0:VEC_LAT-1];
    logic [MAG_W-1:0]          r_mag1_dly [0:VEC_LAT-1];
    logic signed [ANG_W-1:0]   r_ang1_dly [0:VEC_LAT-1];
    logic                      r_zero_dly [0:VEC_LAT-1];

    logic                      out_valid;
    logic [COORD_BITS-1:0]     planar_radius;
    logic signed [COORD_BITS:0] azimuth;
    logic [COORD_BITS-1:0]     full_radius;
    logic [COORD_BITS-1:0]     polar_angle;

    assign en         = !out_valid || i_m_tready;
    assign o_s_tready = en;

    assign x_in = {{(DP_W-COORD_BITS){i_s_tdata[COORD_BITS-1]}},
                   i_s_tdata[0 +: COORD_BITS]} <<< GUARD_BITS;
    assign y_in = {{(DP_W-COORD_BITS){i_s_tdata[2*COORD_BITS-1]}},
                   i_s_tdata[COORD_BITS +: COORD_BITS]} <<< GUARD_BITS;
    assign z_in = {{(DP_W-COORD_BITS){i_s_tdata[3*COORD_BITS-1]}},
                   i_s_tdata[2*COORD_BITS +: COORD_BITS]} <<< GUARD_BITS;

    c2sp_vectoring u_planar (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_tvalid),
        .i_x      (x_in),
        .i_y      (y_in),
        .o_status (st1),
        .o_mag    (mag1),
        .o_ang    (ang1)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z_dly[0]    <= z_in;
            r_mag1_dly[0] <= mag1;
            r_ang1_dly[0] <= ang1;
            r_zero_dly[0] <= st1.zero;
            for (int i = 1; i < VEC_LAT; i++) begin
                r_z_dly[i]    <= r_z_dly[i-1];
                r_mag1_dly[i] <= r_mag1_dly[i-1];
                r_ang1_dly[i] <= r_ang1_dly[i-1];
                r_zero_dly[i] <= r_zero_dly[i-1];
            end
        end
    end

    assign y2_in = signed'(DP_W'(mag1));

    c2sp_vectoring u_spherical (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (st1.valid),
        .i_x      (r_z_dly[VEC_LAT-1]),
        .i_y      (y2_in),
        .o_status (st2),
        .o_mag    (mag2),
        .o_ang    (ang2)
    );

    c2sp_format u_format (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_status        (st2),
        .i_zero1         (r_zero_dly[VEC_LAT-1]),
        .i_mag1          (r_mag1_dly[VEC_LAT-1]),
        .i_ang1          (r_ang1_dly[VEC_LAT-1]),
        .i_mag2          (mag2),
        .i_ang2          (ang2),
        .o_valid         (out_valid),
        .o_planar_radius (planar_radius),
        .o_azimuth       (azimuth),
        .o_full_radius   (full_radius),
        .o_polar_angle   (polar_angle)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                         polar_angle, full_radius, azimuth, planar_radius};

endmodule

@@ src/c2sp_checker.sv @@
// Port-level assertions for the coordinate converter and their bind to the top level.
module c2sp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [c2sp_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import c2sp_pkg::*;

    localparam logic signed [COORD_BITS:0] OUT_PI = signed'((COORD_BITS + 1)'(1) << (COORD_BITS - 1));

    logic signed [COORD_BITS:0] w_az;
    logic [COORD_BITS:0]        w_pol;

    assign w_az  = o_m_tdata[2*COORD_BITS:COORD_BITS];
    assign w_pol = {1'b0, o_m_tdata[4*COORD_BITS:3*COORD_BITS+1]};

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("Output valid after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("Stalled item changed or vanished.");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("Input ready does not follow the output stall.");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_az <= OUT_PI) && (w_az >= -OUT_PI)
                       && (signed'(w_pol) <= OUT_PI))
        else $error("Angle outside its range.");

endmodule

bind cartesian_to_spherical_polar c2sp_checker u_c2sp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
